>>> rtl/sfrc_pkg.sv
`default_nettype none
package sfrc_pkg;

	// Default frame length in bytes, sync byte included
	localparam int FRAME_LEN_DEF = 27;

	localparam logic [7:0] SYNC_BYTE      = 8'h55;
	localparam logic [7:0] PREAMBLE_BYTE  = 8'hAA;
	localparam logic [7:0] INDICATOR_BYTE = 8'h77;
	localparam logic [15:0] TICK_LIMIT_RST = 16'd500;

	// Frame byte positions that carry fixed checks, and the first byte in the XOR
	localparam int POS_PREAMBLE  = 1;
	localparam int POS_XOR_FIRST = 2;
	localparam int POS_SERIAL_HI = 3;
	localparam int POS_SERIAL_LO = 4;
	localparam int POS_INDICATOR = 5;

	// Word kinds on the input channel
	localparam logic [1:0] FUNC_BYTE  = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_START = 2'd2;

	// Receiver phases
	localparam logic [1:0] PH_IDLE    = 2'd0;
	localparam logic [1:0] PH_HUNT    = 2'd1;
	localparam logic [1:0] PH_COLLECT = 2'd2;

	// Result status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_TIMEOUT  = 3'd1;
	localparam logic [2:0] ST_PREAMBLE = 3'd2;
	localparam logic [2:0] ST_SERIAL   = 3'd3;
	localparam logic [2:0] ST_IND      = 3'd4;
	localparam logic [2:0] ST_XOR      = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_LIMIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL_HI  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SERIAL_LO  = 2'd2;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] tick_limit;
		logic [7:0]  serial_hi;
		logic [7:0]  serial_lo;
	} cfg_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] computed_xor;
		logic [7:0] received_check;
	} result_t;

endpackage
`default_nettype wire

>>> rtl/sfrc_if.sv
`default_nettype none
interface sfrc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;

	modport source (output valid, output func, output rx_byte, input ready);
	modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface sfrc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [7:0] computed_xor;
	logic [7:0] received_check;

	modport source (output valid, output status, output computed_xor,
		output received_check, input ready);
	modport sink (input valid, input status, input computed_xor,
		input received_check, output ready);
endinterface

interface sfrc_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sfrc_pkg::CFG_IDX_W-1:0]  index;
	logic [sfrc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/sync_frame_receive_checker.sv
`default_nettype none
// Channel    Dir  Payload                                   Word
// frame_in   in   func[1:0], rx_byte[7:0]                   byte, tick or start
// check_out  out  status[2:0], computed_xor, received_check one checked frame
// cfg        in   index[1:0], data[15:0]                    register write
//
// One word per cycle sustained while check_out is not held: a word sits in
// the input register while the frame state updates, and its result lands in
// the output register as the state takes the word, so check_out.valid comes
// from that register. The rate is set by the sfrc_frame_check state update.
// A pending result stalls the input register only while check_out is held.
// arst_n clears the receiver to idle and loads the register reset values.
module sync_frame_receive_checker #(
	parameter int FRAME_LEN = sfrc_pkg::FRAME_LEN_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	sfrc_in_if.sink      frame_in,
	sfrc_out_if.source   check_out,
	sfrc_cfg_if.sink     cfg
);

	// Configuration regs: user writes only while the block is idle, unchecked
	sfrc_pkg::cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_limit <= sfrc_pkg::TICK_LIMIT_RST;
			cfg_q.serial_hi  <= '0;
			cfg_q.serial_lo  <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				sfrc_pkg::REG_TICK_LIMIT: cfg_q.tick_limit <= cfg.data;
				sfrc_pkg::REG_SERIAL_HI:  cfg_q.serial_hi  <= cfg.data[7:0];
				sfrc_pkg::REG_SERIAL_LO:  cfg_q.serial_lo  <= cfg.data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: hold the word until the frame state has taken it
	logic              valid_s1;
	sfrc_pkg::item_t   item_s1;
	logic              advance_s1;
	logic              res_valid;
	sfrc_pkg::result_t res;
	logic              out_valid_q;
	sfrc_pkg::result_t out_q;

	// Advance unless a result would land on a full, stalled output register
	assign advance_s1     = valid_s1 && (!res_valid || !out_valid_q || check_out.ready);
	assign frame_in.ready = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (frame_in.ready)
			valid_s1 <= frame_in.valid;
	end

	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			item_s1.func    <= frame_in.func;
			item_s1.rx_byte <= frame_in.rx_byte;
		end
	end

	sfrc_frame_check #(
		.FRAME_LEN (FRAME_LEN)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance_s1),
		.item      (item_s1),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: load a fresh result, drop the old one once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (advance_s1 && res_valid)
			out_valid_q <= 1'b1;
		else if (check_out.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && res_valid)
			out_q <= res;
	end

	assign check_out.valid          = out_valid_q;
	assign check_out.status         = out_q.status;
	assign check_out.computed_xor   = out_q.computed_xor;
	assign check_out.received_check = out_q.received_check;

endmodule
`default_nettype wire

>>> rtl/sfrc_frame_check.sv
`default_nettype none
module sfrc_frame_check #(
	parameter int FRAME_LEN = sfrc_pkg::FRAME_LEN_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire sfrc_pkg::item_t   item,
	input  wire sfrc_pkg::cfg_t    cfg,
	output logic                   res_valid,
	output sfrc_pkg::result_t      res
);

	localparam int PW = $clog2(FRAME_LEN);
	localparam logic [PW-1:0] POS_LAST  = PW'(FRAME_LEN - 1);
	localparam logic [PW-1:0] POS_FIRST = PW'(1);
	localparam logic [PW-1:0] POS_PRE   = PW'(sfrc_pkg::POS_PREAMBLE);
	localparam logic [PW-1:0] POS_XOR0  = PW'(sfrc_pkg::POS_XOR_FIRST);
	localparam logic [PW-1:0] POS_SHI   = PW'(sfrc_pkg::POS_SERIAL_HI);
	localparam logic [PW-1:0] POS_SLO   = PW'(sfrc_pkg::POS_SERIAL_LO);
	localparam logic [PW-1:0] POS_IND   = PW'(sfrc_pkg::POS_INDICATOR);

	logic [1:0]    phase_q, phase_d;
	logic [PW-1:0] pos_q, pos_d;
	logic [7:0]    xor_q, xor_d;
	logic [2:0]    err_q, err_d;
	logic [15:0]   tick_q, tick_d;
	logic [15:0]   tick_inc;
	logic [2:0]    chk_err;

	assign tick_inc = tick_q + 16'd1;

	// Fixed-field check for the current frame position
	always_comb begin
		chk_err = sfrc_pkg::ST_OK;
		if (pos_q == POS_PRE && item.rx_byte != sfrc_pkg::PREAMBLE_BYTE)
			chk_err = sfrc_pkg::ST_PREAMBLE;
		else if (pos_q == POS_SHI && item.rx_byte != cfg.serial_hi)
			chk_err = sfrc_pkg::ST_SERIAL;
		else if (pos_q == POS_SLO && item.rx_byte != cfg.serial_lo)
			chk_err = sfrc_pkg::ST_SERIAL;
		else if (pos_q == POS_IND && item.rx_byte != sfrc_pkg::INDICATOR_BYTE)
			chk_err = sfrc_pkg::ST_IND;
	end

	always_comb begin
		phase_d   = phase_q;
		pos_d     = pos_q;
		xor_d     = xor_q;
		err_d     = err_q;
		tick_d    = tick_q;
		res_valid = 1'b0;
		res       = '0;
		if (item.func == sfrc_pkg::FUNC_START) begin
			phase_d = sfrc_pkg::PH_HUNT;
			pos_d   = '0;
			xor_d   = '0;
			err_d   = sfrc_pkg::ST_OK;
			tick_d  = '0;
		end else if (phase_q != sfrc_pkg::PH_IDLE) begin
			case (item.func)
				sfrc_pkg::FUNC_TICK: begin
					tick_d = tick_inc;
					if (tick_inc >= cfg.tick_limit) begin
						phase_d    = sfrc_pkg::PH_IDLE;
						res_valid  = 1'b1;
						res.status = sfrc_pkg::ST_TIMEOUT;
					end
				end
				sfrc_pkg::FUNC_BYTE: begin
					if (phase_q == sfrc_pkg::PH_HUNT) begin
						if (item.rx_byte == sfrc_pkg::SYNC_BYTE) begin
							phase_d = sfrc_pkg::PH_COLLECT;
							pos_d   = POS_FIRST;
						end
					end else if (pos_q == POS_LAST) begin
						phase_d   = sfrc_pkg::PH_IDLE;
						pos_d     = '0;
						res_valid = 1'b1;
						res.status = err_q;
						if (err_q == sfrc_pkg::ST_OK && xor_q != item.rx_byte)
							res.status = sfrc_pkg::ST_XOR;
						res.computed_xor   = xor_q;
						res.received_check = item.rx_byte;
					end else begin
						if (err_q == sfrc_pkg::ST_OK)
							err_d = chk_err;
						if (pos_q >= POS_XOR0)
							xor_d = xor_q ^ item.rx_byte;
						pos_d = pos_q + POS_FIRST;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sfrc_pkg::PH_IDLE;
			pos_q   <= '0;
			xor_q   <= '0;
			err_q   <= sfrc_pkg::ST_OK;
			tick_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			pos_q   <= pos_d;
			xor_q   <= xor_d;
			err_q   <= err_d;
			tick_q  <= tick_d;
		end
	end

	a_res_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> phase_q != sfrc_pkg::PH_IDLE)
		else $error("result raised while idle");

	a_res_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && res_valid |=> phase_q == sfrc_pkg::PH_IDLE)
		else $error("receiver still armed after its result");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.func == sfrc_pkg::FUNC_START
		|=> phase_q == sfrc_pkg::PH_HUNT && tick_q == 16'd0 && err_q == sfrc_pkg::ST_OK)
		else $error("start did not rearm the receiver");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sfrc_pkg::PH_COLLECT |-> pos_q != '0 && pos_q <= POS_LAST)
		else $error("frame position out of range");

endmodule
`default_nettype wire
